// ===== rtl/core/swsr_pkg.sv =====
// shared types and constants for the stop-and-wait session receiver
`timescale 1ns / 1ps
package swsr_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [9:0] MAX_PAYLOAD = 10'd1023;

    localparam logic [2:0] OP_HELLO = 3'd0;
    localparam logic [2:0] OP_WRQ   = 3'd1;
    localparam logic [2:0] OP_DATA  = 3'd2;
    localparam logic [2:0] OP_FIN   = 3'd3;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_CRED = 2'd1,
        ERR_NAME = 2'd2
    } t_err;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_CRED_WORD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRED_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_MIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_MAX  = 2'd3;

    localparam logic [63:0] CRED_WORD_RST = 64'h643938382d333267;
    localparam logic [3:0]  CRED_LEN_RST  = 4'd8;
    localparam logic [7:0]  NAME_MIN_RST  = 8'd4;
    localparam logic [7:0]  NAME_MAX_RST  = 8'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/swsr_if.sv =====
// packet and result channel interfaces
`timescale 1ns / 1ps
interface swsr_pkt_if;
    logic        valid;
    logic        ready;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [2:0]  operation;
    logic [7:0]  seq;
    logic [9:0]  text_len;
    logic [63:0] text_head;
    logic [9:0]  payload_len;

    modport source (output valid, peer_addr, peer_port, operation, seq, text_len,
                    text_head, payload_len, input ready);
    modport sink   (input valid, peer_addr, peer_port, operation, seq, text_len,
                    text_head, payload_len, output ready);
endinterface

interface swsr_res_if;
    logic       valid;
    logic       ready;
    logic       ack_send;
    logic [7:0] ack_seq;
    logic [1:0] ack_error;
    logic       store_payload;
    logic [9:0] store_len;
    logic [3:0] slot;
    logic       table_full;
    logic       session_closed;

    modport source (output valid, ack_send, ack_seq, ack_error, store_payload, store_len,
                    slot, table_full, session_closed, input ready);
    modport sink   (input valid, ack_send, ack_seq, ack_error, store_payload, store_len,
                    slot, table_full, session_closed, output ready);
endinterface

// ===== rtl/core/stop_and_wait_session_receiver.sv =====
// stop-and-wait session receiver: session table scan and alternating-bit check
// steps: accept (ST_IDLE), a scan of all SLOTS table entries, one entry per cycle through one
//   address/port comparator (ST_SCAN), an update step (ST_EXEC), then the result register
//   (ST_DONE); no new packet is taken while one is in flight or while its result
//   waits to be taken
// reset: synchronous active low; clears all session flags, loads register defaults
`timescale 1ns / 1ps
module stop_and_wait_session_receiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    swsr_pkt_if.sink                        i_pkt,
    swsr_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [swsr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swsr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SW = swsr_pkg::SLOT_W;

    swsr_pkg::t_state r_state, n_state;

    // configuration
    logic [63:0] r_cred_word;
    logic [3:0]  r_cred_len;
    logic [7:0]  r_name_min;
    logic [7:0]  r_name_max;

    // session table
    logic        r_active [swsr_pkg::SLOTS];
    logic        r_authed [swsr_pkg::SLOTS];
    logic        r_wopen  [swsr_pkg::SLOTS];
    logic [7:0]  r_last   [swsr_pkg::SLOTS];
    logic [31:0] r_addr   [swsr_pkg::SLOTS];
    logic [15:0] r_port   [swsr_pkg::SLOTS];

    // captured packet
    logic [31:0] r_peer_addr;
    logic [15:0] r_peer_port;
    logic [2:0]  r_op;
    logic [7:0]  r_seq;
    logic [9:0]  r_text_len;
    logic [63:0] r_text_head;
    logic [9:0]  r_payload_len;

    // scan state
    logic [SW-1:0] r_idx;
    logic          r_found;
    logic [SW-1:0] r_hit;
    logic          r_have_free;
    logic [SW-1:0] r_free;

    // result register
    logic        r_ack_send;
    logic [7:0]  r_ack_seq;
    swsr_pkg::t_err r_ack_error;
    logic        r_store;
    logic [9:0]  r_store_len;
    logic [3:0]  r_slot;
    logic        r_full;
    logic        r_closed;

    logic in_fire, out_fire, scan_last, scan_hit;

    // update results
    logic [SW-1:0] sel;
    logic          full;
    logic          cur_auth, cur_wopen;
    logic [7:0]    cur_last;
    logic          cred_ok;
    logic [7:0]    byte_eq;
    logic [3:0]    cred_n;
    logic          e_ack, e_store, e_closed;
    logic [7:0]    e_seq;
    swsr_pkg::t_err e_err;
    logic [9:0]    e_len;
    logic          w_auth, w_wopen, w_active;
    logic [7:0]    w_last;

    assign in_fire   = i_pkt.valid & i_pkt.ready;
    assign out_fire  = o_res.valid & o_res.ready;
    assign scan_last = (r_idx == SW'(swsr_pkg::SLOTS - 1));
    assign scan_hit  = r_active[r_idx] && (r_addr[r_idx] == r_peer_addr)
                       && (r_port[r_idx] == r_peer_port);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swsr_pkg::ST_IDLE: if (in_fire) n_state = swsr_pkg::ST_SCAN;
            swsr_pkg::ST_SCAN: if (scan_last) n_state = swsr_pkg::ST_EXEC;
            swsr_pkg::ST_EXEC: n_state = swsr_pkg::ST_DONE;
            swsr_pkg::ST_DONE: if (out_fire) n_state = swsr_pkg::ST_IDLE;
            default:           n_state = swsr_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_pkt.ready = (r_state == swsr_pkg::ST_IDLE);
        o_res.valid = (r_state == swsr_pkg::ST_DONE);
    end

    // credential compare
    always_comb begin
        cred_n = (r_cred_len > 4'd8) ? 4'd8 : r_cred_len;
        for (int b = 0; b < 8; b++) begin
            byte_eq[b] = (4'(b) >= cred_n)
                         || (r_text_head[8*b +: 8] == r_cred_word[8*b +: 8]);
        end
        cred_ok = (r_text_len == {6'd0, r_cred_len}) && (&byte_eq);
    end

    // packet handling on the selected slot
    always_comb begin
        sel       = r_found ? r_hit : r_free;
        full      = !r_found && !r_have_free;
        cur_auth  = r_found && r_authed[sel];
        cur_wopen = r_found && r_wopen[sel];
        cur_last  = r_found ? r_last[sel] : 8'd0;
        e_ack     = 1'b0;
        e_seq     = 8'd0;
        e_err     = swsr_pkg::ERR_NONE;
        e_store   = 1'b0;
        e_len     = 10'd0;
        e_closed  = 1'b0;
        w_active  = 1'b1;
        w_auth    = cur_auth;
        w_wopen   = cur_wopen;
        w_last    = cur_last;
        unique case (r_op)
            swsr_pkg::OP_HELLO: begin
                e_ack = 1'b1;
                if (cred_ok) begin
                    w_auth = 1'b1;
                    w_last = 8'd0;
                end else begin
                    e_err = swsr_pkg::ERR_CRED;
                end
            end
            swsr_pkg::OP_WRQ: begin
                if (cur_auth) begin
                    e_ack = 1'b1;
                    e_seq = 8'd1;
                    if ((r_text_len < {2'd0, r_name_min}) || (r_text_len > {2'd0, r_name_max}))
                    begin
                        e_err = swsr_pkg::ERR_NAME;
                    end else begin
                        w_wopen = 1'b1;
                        w_last  = 8'd1;
                    end
                end
            end
            swsr_pkg::OP_DATA: begin
                if (cur_wopen) begin
                    e_ack = 1'b1;
                    if (r_seq != ((cur_last == 8'd0) ? 8'd1 : 8'd0)) begin
                        e_seq = cur_last;
                    end else begin
                        e_store = 1'b1;
                        e_len   = (r_payload_len > swsr_pkg::MAX_PAYLOAD)
                                  ? swsr_pkg::MAX_PAYLOAD : r_payload_len;
                        w_last  = r_seq;
                        e_seq   = r_seq;
                    end
                end
            end
            swsr_pkg::OP_FIN: begin
                e_ack    = 1'b1;
                e_seq    = r_seq;
                e_closed = 1'b1;
                w_active = 1'b0;
                w_auth   = 1'b0;
                w_wopen  = 1'b0;
                w_last   = 8'd0;
            end
            default: begin
            end
        endcase
    end

    // control, configuration and session flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swsr_pkg::ST_IDLE;
            r_cred_word <= swsr_pkg::CRED_WORD_RST;
            r_cred_len  <= swsr_pkg::CRED_LEN_RST;
            r_name_min  <= swsr_pkg::NAME_MIN_RST;
            r_name_max  <= swsr_pkg::NAME_MAX_RST;
            for (int k = 0; k < swsr_pkg::SLOTS; k++) begin
                r_active[k] <= 1'b0;
                r_authed[k] <= 1'b0;
                r_wopen[k]  <= 1'b0;
                r_last[k]   <= 8'd0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    swsr_pkg::CFG_CRED_WORD: r_cred_word <= i_cfg_data[63:0];
                    swsr_pkg::CFG_CRED_LEN:  r_cred_len  <= i_cfg_data[3:0];
                    swsr_pkg::CFG_NAME_MIN:  r_name_min  <= i_cfg_data[7:0];
                    swsr_pkg::CFG_NAME_MAX:  r_name_max  <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == swsr_pkg::ST_EXEC && !full) begin
                r_active[sel] <= w_active;
                r_authed[sel] <= w_auth;
                r_wopen[sel]  <= w_wopen;
                r_last[sel]   <= w_last;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_peer_addr   <= i_pkt.peer_addr;
            r_peer_port   <= i_pkt.peer_port;
            r_op          <= i_pkt.operation;
            r_seq         <= i_pkt.seq;
            r_text_len    <= i_pkt.text_len;
            r_text_head   <= i_pkt.text_head;
            r_payload_len <= i_pkt.payload_len;
            r_idx         <= '0;
            r_found       <= 1'b0;
            r_have_free   <= 1'b0;
            r_hit         <= '0;
            r_free        <= '0;
        end
        if (r_state == swsr_pkg::ST_SCAN) begin
            if (!scan_last) r_idx <= r_idx + SW'(1);
            if (r_active[r_idx]) begin
                if (!r_found && scan_hit) begin
                    r_found <= 1'b1;
                    r_hit   <= r_idx;
                end
            end else if (!r_have_free) begin
                r_have_free <= 1'b1;
                r_free      <= r_idx;
            end
        end
        if (r_state == swsr_pkg::ST_EXEC) begin
            if (!full && !r_found) begin
                r_addr[sel] <= r_peer_addr;
                r_port[sel] <= r_peer_port;
            end
            r_ack_send  <= !full && e_ack;
            r_ack_seq   <= full ? 8'd0 : e_seq;
            r_ack_error <= full ? swsr_pkg::ERR_NONE : e_err;
            r_store     <= !full && e_store;
            r_store_len <= full ? 10'd0 : e_len;
            r_slot      <= full ? 4'd0 : 4'(sel);
            r_full      <= full;
            r_closed    <= !full && e_closed;
        end
    end

    assign o_res.ack_send       = r_ack_send;
    assign o_res.ack_seq        = r_ack_seq;
    assign o_res.ack_error      = r_ack_error;
    assign o_res.store_payload  = r_store;
    assign o_res.store_len      = r_store_len;
    assign o_res.slot           = r_slot;
    assign o_res.table_full     = r_full;
    assign o_res.session_closed = r_closed;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_res.valid && i_pkt.ready))
        else $error("packet taken while a result waits");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == swsr_pkg::ST_SCAN) && (r_idx == '0) && !r_found)
        else $error("scan did not restart after a transfer");

    a_full_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.table_full) |->
            (!o_res.ack_send && !o_res.store_payload && !o_res.session_closed))
        else $error("full table result carries an action");

    a_store_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.store_payload) |->
            (o_res.ack_send && (o_res.ack_seq == r_seq)))
        else $error("stored payload without matching ack");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the stop-and-wait session receiver
`timescale 1ns / 1ps
module testbench;

    localparam logic [2:0]  OP_OTHER     = 3'd4;
    localparam logic [2:0]  OP_OTHER_TOP = 3'd7;
    localparam logic [31:0] ADDR_A       = 32'hFFFF_FFFF;
    localparam logic [15:0] PORT_A       = 16'hFFFF;
    localparam logic [31:0] ADDR_B       = 32'h0000_0000;
    localparam logic [15:0] PORT_B       = 16'h0000;
    localparam logic [31:0] ADDR_C       = 32'h8000_0001;
    localparam logic [15:0] PORT_C       = 16'h8000;
    localparam int POOL          = 20;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
        logic [2:0]  operation;
        logic [7:0]  seq;
        logic [9:0]  text_len;
        logic [63:0] text_head;
        logic [9:0]  payload_len;
    } t_pkt;

    typedef struct packed {
        logic       ack_send;
        logic [7:0] ack_seq;
        swsr_pkg::t_err ack_error;
        logic       store_payload;
        logic [9:0] store_len;
        logic [3:0] slot;
        logic       table_full;
        logic       session_closed;
    } t_res;

    typedef struct {
        t_pkt pkt;
        bit   typed;
        t_res want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                            cfg_we;
    logic [swsr_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [swsr_pkg::CFG_DATA_W-1:0] cfg_data;

    swsr_pkt_if pkt_if ();
    swsr_res_if res_if ();

    stop_and_wait_session_receiver DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (pkt_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // session table and register copies
    bit          sess_active   [swsr_pkg::SLOTS];
    logic [31:0] sess_addr     [swsr_pkg::SLOTS];
    logic [15:0] sess_port     [swsr_pkg::SLOTS];
    bit          sess_authed   [swsr_pkg::SLOTS];
    bit          sess_open     [swsr_pkg::SLOTS];
    logic [7:0]  sess_last_seq [swsr_pkg::SLOTS];
    logic [63:0] cred_word;
    logic [3:0]  cred_len;
    logic [7:0]  name_min;
    logic [7:0]  name_max;

    logic [31:0] pool_addr [POOL];
    logic [15:0] pool_port [POOL];
    int          pool_n;

    t_res replies_due [$];
    t_row dir_rows [$];
    int   faults;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   rx_hold_req;
    bit   rx_hold_done;
    int   rx_hold_left;

    function automatic void clear_session(int i);
        sess_active[i]   = 1'b0;
        sess_addr[i]     = '0;
        sess_port[i]     = '0;
        sess_authed[i]   = 1'b0;
        sess_open[i]     = 1'b0;
        sess_last_seq[i] = '0;
    endfunction

    function automatic logic [63:0] cred_mask();
        int n;
        n = (cred_len > 4'd8) ? 8 : int'(cred_len);
        return (n >= 8) ? ~64'd0 : (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic t_res predict_session_step(t_pkt p);
        t_res r;
        int s, free_slot;
        bit found, have_free;
        r = '0;
        s = 0;
        free_slot = 0;
        found = 1'b0;
        have_free = 1'b0;
        for (int i = 0; i < swsr_pkg::SLOTS; i++) begin
            if (sess_active[i]) begin
                if (!found && sess_addr[i] == p.peer_addr && sess_port[i] == p.peer_port) begin
                    found = 1'b1;
                    s = i;
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_slot = i;
            end
        end
        if (!found) begin
            if (!have_free) begin
                r.table_full = 1'b1;
                return r;
            end
            s = free_slot;
            clear_session(s);
            sess_active[s] = 1'b1;
            sess_addr[s]   = p.peer_addr;
            sess_port[s]   = p.peer_port;
        end
        r.slot = 4'(s);
        case (p.operation)
            swsr_pkg::OP_HELLO: begin
                r.ack_send = 1'b1;
                if (p.text_len == 10'(cred_len) &&
                    ((p.text_head ^ cred_word) & cred_mask()) == 64'd0) begin
                    sess_authed[s]   = 1'b1;
                    sess_last_seq[s] = 8'd0;
                end else begin
                    r.ack_error = swsr_pkg::ERR_CRED;
                end
            end
            swsr_pkg::OP_WRQ: begin
                if (sess_authed[s]) begin
                    r.ack_send = 1'b1;
                    r.ack_seq  = 8'd1;
                    if (p.text_len < name_min || p.text_len > name_max) begin
                        r.ack_error = swsr_pkg::ERR_NAME;
                    end else begin
                        sess_open[s]     = 1'b1;
                        sess_last_seq[s] = 8'd1;
                    end
                end
            end
            swsr_pkg::OP_DATA: begin
                if (sess_open[s]) begin
                    r.ack_send = 1'b1;
                    if (p.seq != ((sess_last_seq[s] == 8'd0) ? 8'd1 : 8'd0)) begin
                        r.ack_seq = sess_last_seq[s];
                    end else begin
                        r.store_payload  = 1'b1;
                        r.store_len      = (p.payload_len > swsr_pkg::MAX_PAYLOAD)
                                           ? swsr_pkg::MAX_PAYLOAD : p.payload_len;
                        sess_last_seq[s] = p.seq;
                        r.ack_seq        = p.seq;
                    end
                end
            end
            swsr_pkg::OP_FIN: begin
                r.ack_send       = 1'b1;
                r.ack_seq        = p.seq;
                r.session_closed = 1'b1;
                clear_session(s);
            end
            default: ;
        endcase
        return r;
    endfunction

    // mostly well-formed session traffic from the peer pool, some noise
    function automatic t_pkt make_session_packet();
        t_pkt p;
        int roll, k, s;
        logic [63:0] mask;
        k = $urandom_range(pool_n - 1);
        p.peer_addr   = pool_addr[k];
        p.peer_port   = pool_port[k];
        p.operation   = 3'($urandom_range(7));
        p.seq         = 8'($urandom);
        p.text_len    = 10'($urandom);
        p.text_head   = {$urandom, $urandom};
        p.payload_len = 10'($urandom);
        roll = $urandom_range(99);
        if (roll < 8)
            return p;
        if (roll < 10) begin
            p.peer_addr = $urandom;
            p.peer_port = 16'($urandom);
            p.operation = swsr_pkg::OP_FIN;
            return p;
        end
        s = -1;
        for (int i = 0; i < swsr_pkg::SLOTS; i++)
            if (s < 0 && sess_active[i] && sess_addr[i] == p.peer_addr &&
                sess_port[i] == p.peer_port)
                s = i;
        if (roll < 14) begin
            p.operation = swsr_pkg::OP_FIN;
        end else if (roll < 16) begin
            p.operation = OP_OTHER + 3'($urandom_range(3));
        end else if (s < 0 || !sess_authed[s]) begin
            p.operation = swsr_pkg::OP_HELLO;
            if (roll >= 24) begin
                mask = cred_mask();
                p.text_len  = 10'(cred_len);
                p.text_head = (p.text_head & ~mask) | (cred_word & mask);
            end
        end else if (!sess_open[s]) begin
            p.operation = swsr_pkg::OP_WRQ;
            if (roll >= 24)
                p.text_len = 10'($urandom_range(name_min, name_max));
        end else begin
            p.operation = swsr_pkg::OP_DATA;
            if (roll >= 24)
                p.seq = (sess_last_seq[s] == 8'd0) ? 8'd1 : 8'd0;
        end
        return p;
    endfunction

    function automatic string reply_text(t_res r);
        return $sformatf("ack=%0b seq=%0d err=%0d store=%0b len=%0d slot=%0d full=%0b closed=%0b",
                         r.ack_send, r.ack_seq, r.ack_error, r.store_payload, r.store_len,
                         r.slot, r.table_full, r.session_closed);
    endfunction

    task automatic offer_packet(input t_pkt p, input bit typed, input t_res want);
        t_res due;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            pkt_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        pkt_if.valid       <= 1'b1;
        pkt_if.peer_addr   <= p.peer_addr;
        pkt_if.peer_port   <= p.peer_port;
        pkt_if.operation   <= p.operation;
        pkt_if.seq         <= p.seq;
        pkt_if.text_len    <= p.text_len;
        pkt_if.text_head   <= p.text_head;
        pkt_if.payload_len <= p.payload_len;
        do @(posedge i_clk); while (!pkt_if.ready);
        due = predict_session_step(p);
        replies_due.push_back(typed ? want : due);
    endtask

    task automatic drain_replies();
        pkt_if.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_config(logic [63:0] word, logic [3:0] len, logic [7:0] lo,
                              logic [7:0] hi);
        logic [swsr_pkg::CFG_IDX_W-1:0] regs [4];
        logic [63:0]                    vals [4];
        regs = '{swsr_pkg::CFG_CRED_WORD, swsr_pkg::CFG_CRED_LEN, swsr_pkg::CFG_NAME_MIN,
                 swsr_pkg::CFG_NAME_MAX};
        vals = '{word, 64'(len), 64'(lo), 64'(hi)};
        for (int i = 0; i < 4; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= regs[i];
            cfg_data <= vals[i];
            @(posedge i_clk);
        end
        cfg_we    <= 1'b0;
        cred_word = word;
        cred_len  = len;
        name_min  = lo;
        name_max  = hi;
    endtask

    // result sink: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_hold_left <= 0;
            rx_hold_done <= 1'b0;
        end else if (rx_hold_req && !rx_hold_done) begin
            rx_hold_done <= 1'b1;
            rx_hold_left <= HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_res seen, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen.ack_send       = res_if.ack_send;
            seen.ack_seq        = res_if.ack_seq;
            seen.ack_error      = swsr_pkg::t_err'(res_if.ack_error);
            seen.store_payload  = res_if.store_payload;
            seen.store_len      = res_if.store_len;
            seen.slot           = res_if.slot;
            seen.table_full     = res_if.table_full;
            seen.session_closed = res_if.session_closed;
            if (replies_due.size() == 0) begin
                if (faults < 10)
                    $display("unexpected result transfer: %s", reply_text(seen));
                faults++;
            end else begin
                want = replies_due.pop_front();
                if (seen !== want) begin
                    if (faults < 10)
                        $display("result mismatch\n  expected %s\n  actual   %s",
                                 reply_text(want), reply_text(seen));
                    faults++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_pkt fill;
        t_res want;
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        pkt_if.valid       = 1'b0;
        pkt_if.peer_addr   = '0;
        pkt_if.peer_port   = '0;
        pkt_if.operation   = '0;
        pkt_if.seq         = '0;
        pkt_if.text_len    = '0;
        pkt_if.text_head   = '0;
        pkt_if.payload_len = '0;
        faults             = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        rx_hold_req        = 1'b0;
        pool_n             = POOL;
        cred_word          = swsr_pkg::CRED_WORD_RST;
        cred_len           = swsr_pkg::CRED_LEN_RST;
        name_min           = swsr_pkg::NAME_MIN_RST;
        name_max           = swsr_pkg::NAME_MAX_RST;
        for (int i = 0; i < swsr_pkg::SLOTS; i++)
            clear_session(i);
        for (int k = 0; k < POOL; k++) begin
            pool_addr[k] = $urandom;
            pool_port[k] = {11'($urandom), 5'(k + 1)};
        end

        dir_rows.push_back('{'{ADDR_A, PORT_A, swsr_pkg::OP_HELLO, 8'd0, 10'd8,
                               swsr_pkg::CRED_WORD_RST, 10'd0},
                1'b1, '{1'b1, 8'd0, swsr_pkg::ERR_NONE, 1'b0, 10'd0, 4'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{'{ADDR_B, PORT_B, swsr_pkg::OP_WRQ, 8'd0, 10'd5, 64'd0, 10'd0},
                1'b0, '0});
        dir_rows.push_back('{'{ADDR_B, PORT_B, swsr_pkg::OP_HELLO, 8'd0, 10'd8,
                               ~swsr_pkg::CRED_WORD_RST, 10'd0},
                1'b1, '{1'b1, 8'd0, swsr_pkg::ERR_CRED, 1'b0, 10'd0, 4'd1, 1'b0, 1'b0}});
        dir_rows.push_back('{'{ADDR_A, PORT_A, swsr_pkg::OP_WRQ, 8'd0, 10'd3, 64'd0, 10'd0},
                1'b1, '{1'b1, 8'd1, swsr_pkg::ERR_NAME, 1'b0, 10'd0, 4'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{'{ADDR_A, PORT_A, swsr_pkg::OP_WRQ, 8'd0, 10'd1023, 64'd0,
                               10'd0},
                1'b1, '{1'b1, 8'd1, swsr_pkg::ERR_NAME, 1'b0, 10'd0, 4'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{'{ADDR_A, PORT_A, swsr_pkg::OP_WRQ, 8'd0, 10'd4, 64'd0, 10'd0},
                1'b0, '0});
        dir_rows.push_back('{'{ADDR_A, PORT_A, swsr_pkg::OP_DATA, 8'd0, 10'd0, 64'd0,
                               10'd1023},
                1'b1, '{1'b1, 8'd0, swsr_pkg::ERR_NONE, 1'b1, 10'd1023, 4'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{'{ADDR_A, PORT_A, swsr_pkg::OP_DATA, 8'd0, 10'd0, 64'd0, 10'd17},
                1'b0, '0});
        dir_rows.push_back('{'{ADDR_A, PORT_A, swsr_pkg::OP_DATA, 8'd1, 10'd0, 64'd0, 10'd0},
                1'b0, '0});
        dir_rows.push_back('{'{ADDR_A, PORT_A, swsr_pkg::OP_DATA, 8'd255, 10'd0, 64'd0, 10'd5},
                1'b0, '0});
        dir_rows.push_back('{'{ADDR_A, PORT_A, swsr_pkg::OP_HELLO, 8'd0, 10'd7,
                               swsr_pkg::CRED_WORD_RST, 10'd0},
                1'b1, '{1'b1, 8'd0, swsr_pkg::ERR_CRED, 1'b0, 10'd0, 4'd0, 1'b0, 1'b0}});
        dir_rows.push_back('{'{ADDR_A, PORT_A, swsr_pkg::OP_WRQ, 8'd0, 10'd10, 64'd0, 10'd0},
                1'b0, '0});
        dir_rows.push_back('{'{ADDR_B, PORT_B, swsr_pkg::OP_DATA, 8'd1, 10'd0, 64'd0, 10'd9},
                1'b0, '0});
        dir_rows.push_back('{'{ADDR_A, PORT_A, OP_OTHER, 8'd0, 10'd0, ~64'd0, 10'd0},
                1'b0, '0});
        dir_rows.push_back('{'{ADDR_C, PORT_C, OP_OTHER_TOP, 8'd0, 10'd0, 64'd0, 10'd0},
                1'b0, '0});
        dir_rows.push_back('{'{ADDR_A, PORT_A, swsr_pkg::OP_FIN, 8'd255, 10'd0, 64'd0, 10'd0},
                1'b1, '{1'b1, 8'd255, swsr_pkg::ERR_NONE, 1'b0, 10'd0, 4'd0, 1'b0, 1'b1}});
        dir_rows.push_back('{'{ADDR_B, PORT_B, swsr_pkg::OP_FIN, 8'd0, 10'd0, 64'd0, 10'd0},
                1'b0, '0});
        dir_rows.push_back('{'{ADDR_C, PORT_C, swsr_pkg::OP_FIN, 8'h5A, 10'd0, 64'd0, 10'd0},
                1'b0, '0});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            offer_packet(dir_rows[i].pkt, dir_rows[i].typed, dir_rows[i].want);

        // claim every slot, then one more peer finds the table full
        for (int k = 0; k <= swsr_pkg::SLOTS; k++) begin
            fill = '{pool_addr[k], pool_port[k], OP_OTHER, 8'd0, 10'd0, 64'd0, 10'd0};
            want = '0;
            if (k < swsr_pkg::SLOTS)
                want.slot = 4'(k);
            else
                want.table_full = 1'b1;
            offer_packet(fill, 1'b1, want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_replies();
            case (ph)
                1: set_config({$urandom, $urandom}, 4'd8, 8'd0, 8'd255);
                2: set_config({$urandom, $urandom}, 4'd0, 8'd255, 8'd255);
                3: set_config(~64'd0, 4'd15, 8'd200, 8'd5);
                4: set_config(64'd0, 4'd1, 8'd0, 8'd0);
                5: set_config({$urandom, $urandom}, 4'($urandom_range(1, 8)),
                              swsr_pkg::NAME_MIN_RST, swsr_pkg::NAME_MAX_RST);
                6: set_config({$urandom, $urandom}, 4'($urandom_range(15)),
                              8'($urandom_range(20)), 8'($urandom_range(10, 40)));
                default: ;
            endcase
            pool_n = (ph % 3 == 1) ? 6 : POOL;
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                end
                default: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    drain_replies();
                if (ph == 2 && n == 30)
                    rx_hold_req = 1'b1;
                offer_packet(make_session_packet(), 1'b0, '0);
            end
        end

        pkt_if.valid <= 1'b0;
        for (int c = 0; c < 5000 && replies_due.size() != 0; c++)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        faults += replies_due.size();
        if (faults == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
